// ===== hw/rtl/citp_pkg.sv =====
package citp_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 32;
   localparam int MAX_W   = VALUE_W - 1;
   localparam int DIGIT_W = 6;
   localparam int FULL_W  = VALUE_W + 4;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = VALUE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_VALUE   = 2'd0,
      CSR_MIN_VALUE   = 2'd1,
      CSR_HEX_DEFAULT = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

   // Value of a character as a digit of base up to 36; non-alphanumeric characters count as zero.
   function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         d = c - CH_UP_A + 8'd10;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         d = c - CH_LO_A + 8'd10;
      end
      return d[DIGIT_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/citp_req_if.sv =====
interface citp_req_if;
   import citp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ===== hw/rtl/citp_rsp_if.sv =====
interface citp_rsp_if;
   import citp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ===== hw/rtl/clamped_integer_text_parser.sv =====
// Parses one signed integer from a character stream, one character per req transaction,
// and returns one rsp transaction after the character marked is_last. A leading '-' makes
// the number negative; a "0x" prefix, a first character 'A' or 'a', or hex_default selects
// hexadecimal, otherwise decimal. The first character that is not a digit ends the parse,
// and with a nonzero max_value the magnitude saturates at max_value. The final magnitude is
// clamped against min_value before it is signed. The block takes one character every
// cycle unless a result is held in both the finish stage and the output register; the
// rate is set by the single multiply-add and limit compare on the running total. The
// finish stage takes the last digit folded in, the output register the clamped, signed
// result. Configuration registers may be written only while no result is outstanding.
module clamped_integer_text_parser (
   input  logic                              clock,
   input  logic                              reset,
   citp_req_if.sink                          req_ch,
   citp_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [citp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [citp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import citp_pkg::*;

   typedef enum logic [2:0] {
      PH_START,
      PH_FIRST,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   // Configuration registers.
   logic [MAX_W-1:0]          max_value_ff;
   logic signed [VALUE_W-1:0] min_value_ff;
   logic                      hex_default_ff;

   // Parse state.
   phase_type                 phase_ff, phase_in;
   phase_type                 phase_dec;
   logic                      neg_ff, neg_in;
   logic                      hex_ff, hex_in;
   logic [VALUE_W-1:0]        total_ff, total_in;

   // Finish stage: magnitude and sign of a completed text.
   logic                      fin_valid_ff, fin_valid_in;
   logic [VALUE_W-1:0]        fin_mag_ff, fin_mag_in;
   logic                      fin_neg_ff, fin_neg_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]        rsp_value_ff, rsp_value_in;

   logic                      req_accept;
   logic                      out_free;
   logic                      fin_adv;

   // Digit path.
   logic [CHAR_W-1:0]         c;
   logic                      sel_hex;
   logic                      do_digit;
   logic                      digit_ok;
   logic [DIGIT_W-1:0]        digit;
   logic [FULL_W-1:0]         total_wide;
   logic [FULL_W-1:0]         full;
   logic                      over_max;

   // Clamp path.
   logic signed [VALUE_W:0]   mag;
   logic signed [VALUE_W:0]   min_wide;
   logic signed [VALUE_W:0]   lim;
   logic signed [VALUE_W:0]   res_mag;
   logic                      res_neg;
   logic signed [VALUE_W:0]   res_signed;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign fin_adv      = fin_valid_ff && out_free;
   assign req_ch.ready = !fin_valid_ff || out_free;
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.value = rsp_value_ff;

   assign c = req_ch.char_code;

   // Phase decode: decides whether this character is taken as a digit and in which base.
   always_comb begin
      phase_dec = phase_ff;
      neg_in    = neg_ff;
      sel_hex   = hex_ff;
      do_digit  = 1'b0;
      case (phase_ff)
         PH_START, PH_FIRST: begin
            if (phase_ff == PH_START && c == CH_MINUS) begin
               neg_in    = 1'b1;
               phase_dec = PH_FIRST;
            end else if (c == CH_ZERO) begin
               phase_dec = PH_ZERO;
            end else begin
               sel_hex  = (c == CH_UP_A) || (c == CH_LO_A) || hex_default_ff;
               do_digit = 1'b1;
            end
         end
         PH_ZERO: begin
            if (c == CH_LO_X) begin
               sel_hex   = 1'b1;
               phase_dec = PH_DIGITS;
            end else begin
               sel_hex  = hex_default_ff;
               do_digit = 1'b1;
            end
         end
         PH_DIGITS: begin
            do_digit = 1'b1;
         end
         default: begin
            phase_dec = PH_DONE;
         end
      endcase
   end

   // Multiply-add of one digit and the saturation compare.
   always_comb begin
      digit      = digit_value(c);
      digit_ok   = sel_hex ? (c >= CH_ZERO && c <= CH_LO_Z) : (c >= CH_ZERO && c <= CH_NINE);
      total_wide = FULL_W'(total_ff);
      if (sel_hex) begin
         full = (total_wide << 4) + FULL_W'(digit);
      end else begin
         full = (total_wide << 3) + (total_wide << 1) + FULL_W'(digit);
      end
      over_max = (max_value_ff != '0) && (full > FULL_W'(max_value_ff));
   end

   always_comb begin
      phase_in = phase_dec;
      hex_in   = sel_hex;
      total_in = total_ff;
      if (do_digit) begin
         if (!digit_ok) begin
            phase_in = PH_DONE;
         end else if (over_max) begin
            // Saturated: the kept magnitude is the limit and the rest of the text is ignored.
            total_in = VALUE_W'(max_value_ff);
            phase_in = PH_DONE;
         end else begin
            total_in = full[VALUE_W-1:0];
            phase_in = PH_DIGITS;
         end
      end
   end

   // Clamp against min_value and apply the sign.
   always_comb begin
      mag      = {fin_mag_ff[VALUE_W-1], fin_mag_ff};
      min_wide = {min_value_ff[VALUE_W-1], min_value_ff};
      lim      = -min_wide;
      res_mag  = mag;
      res_neg  = fin_neg_ff;
      if (min_value_ff < 0) begin
         if (fin_neg_ff && mag > lim) begin
            res_mag = lim;
         end
      end else if (mag < min_wide || fin_neg_ff) begin
         res_mag = min_wide;
         res_neg = 1'b0;
      end
      res_signed   = res_neg ? -res_mag : res_mag;
      rsp_value_in = res_signed[VALUE_W-1:0];
   end

   always_comb begin
      fin_mag_in   = total_in;
      fin_neg_in   = neg_in;
      fin_valid_in = (req_accept && req_ch.is_last) || (fin_valid_ff && !fin_adv);
      rsp_valid_in = fin_adv || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff   <= '0;
         min_value_ff   <= '0;
         hex_default_ff <= 1'b0;
         phase_ff       <= PH_START;
         neg_ff         <= 1'b0;
         hex_ff         <= 1'b0;
         total_ff       <= '0;
         fin_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_MAX_VALUE:   max_value_ff   <= csr_wdata[MAX_W-1:0];
               CSR_MIN_VALUE:   min_value_ff   <= csr_wdata[VALUE_W-1:0];
               CSR_HEX_DEFAULT: hex_default_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_accept) begin
            if (req_ch.is_last) begin
               // The text is complete; start the next one from scratch.
               phase_ff <= PH_START;
               neg_ff   <= 1'b0;
               hex_ff   <= 1'b0;
               total_ff <= '0;
            end else begin
               phase_ff <= phase_in;
               neg_ff   <= neg_in;
               hex_ff   <= hex_in;
               total_ff <= total_in;
            end
         end
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept && req_ch.is_last) begin
         fin_mag_ff <= fin_mag_in;
         fin_neg_ff <= fin_neg_in;
      end
      if (fin_adv) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   // A last character always leaves a pending result in the finish stage.
   a_last_loads_fin: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_ch.is_last |=> fin_valid_ff)
      else $error("last character did not load the finish stage");

   // After a last character the parse state is back at its start.
   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_ch.is_last |=> phase_ff == PH_START && total_ff == '0 && !neg_ff)
      else $error("parse state not cleared after last character");

   // Once the parse has ended, further characters leave the total untouched.
   a_done_holds_total: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_ch.is_last && phase_ff == PH_DONE |=> $stable(total_ff))
      else $error("total changed after the parse ended");

   // Input stalls only when both the finish stage and the output register are blocked.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> fin_valid_ff && rsp_valid_ff && !rsp_ch.ready)
      else $error("input stalled without a blocked result");

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import citp_pkg::*;

   // The block answers through its finish stage and output register. Before any
   // register write we let SETTLE_CYCLES go by.
   localparam int DUT_LATENCY     = 2;
   localparam int SETTLE_CYCLES   = DUT_LATENCY + 4;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int PHASE_CHARS     = 112;
   localparam int RANDOM_PHASES   = 8;

   // Where the scan of one text stands, mirrored from the block's behavior.
   typedef enum logic [2:0] {
      SCAN_START,
      SCAN_SIGN_SEEN,
      SCAN_LEADING_ZERO,
      SCAN_DIGITS,
      SCAN_DONE
   } scan_phase_type;

   // The tracker mirrors the register file and the parse state of the block. Every
   // accepted character goes through note_char, which queues the parsed value when
   // the character closes a text. Every accepted result goes through check_value.
   class parse_scoreboard;
      logic [MAX_W-1:0]          max_limit;
      logic signed [VALUE_W-1:0] min_limit;
      logic                      hex_default;
      scan_phase_type            scan;
      logic                      negative;
      logic                      hex_mode;
      logic [VALUE_W-1:0]        total;
      logic [VALUE_W-1:0]        kept;
      logic signed [VALUE_W-1:0] values_due[$];
      int unsigned               chars_seen;
      int unsigned               values_checked;
      int unsigned               failures;

      function new();
         max_limit      = '0;
         min_limit      = '0;
         hex_default    = 1'b0;
         chars_seen     = 0;
         values_checked = 0;
         failures       = 0;
         clear_text();
      endfunction

      function void clear_text();
         scan     = SCAN_START;
         negative = 1'b0;
         hex_mode = 1'b0;
         total    = '0;
         kept     = '0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MAX_VALUE:   max_limit = data[MAX_W-1:0];
            CSR_MIN_VALUE:   min_limit = data;
            CSR_HEX_DEFAULT: hex_default = data[0];
            default: ;
         endcase
      endfunction

      // Letters of either case fold onto the lower-case range.
      function logic [5:0] char_weight(logic [CHAR_W-1:0] c);
         logic [CHAR_W-1:0] folded;
         folded = c | 8'h20;
         if (c >= CH_ZERO && c <= CH_NINE) return 6'(c - CH_ZERO);
         if (folded >= CH_LO_A && folded <= CH_LO_Z) return 6'(folded - CH_LO_A + 8'd10);
         return '0;
      endfunction

      function void absorb_digit(logic [CHAR_W-1:0] c);
         logic            in_base;
         longint unsigned radix;
         longint unsigned grown;
         in_base = hex_mode ? (c >= CH_ZERO && c <= CH_LO_Z) : (c >= CH_ZERO && c <= CH_NINE);
         if (!in_base) begin
            scan = SCAN_DONE;
            return;
         end
         scan  = SCAN_DIGITS;
         radix = hex_mode ? 64'd16 : 64'd10;
         grown = total;
         grown = grown * radix + char_weight(c);
         if (max_limit == '0) begin
            total = grown[VALUE_W-1:0];
            kept  = total;
         end else if (grown <= max_limit) begin
            total = grown[VALUE_W-1:0];
            kept  = total;
         end else begin
            kept = max_limit;
            scan = SCAN_DONE;
         end
      endfunction

      function logic signed [VALUE_W-1:0] close_text();
         longint mag;
         longint lim;
         logic   neg;
         mag = $signed(kept);
         neg = negative;
         if (min_limit < 0) begin
            lim = min_limit;
            lim = -lim;
            if (neg && mag > lim) mag = lim;
         end else if (mag < min_limit || neg) begin
            mag = min_limit;
            neg = 1'b0;
         end
         if (neg) mag = -mag;
         return mag[VALUE_W-1:0];
      endfunction

      function void note_char(logic [CHAR_W-1:0] c, logic last);
         chars_seen++;
         case (scan)
            SCAN_START, SCAN_SIGN_SEEN: begin
               if (scan == SCAN_START && c == CH_MINUS) begin
                  negative = 1'b1;
                  scan     = SCAN_SIGN_SEEN;
               end else if (c == CH_ZERO) begin
                  scan = SCAN_LEADING_ZERO;
               end else begin
                  hex_mode = (c == CH_UP_A) || (c == CH_LO_A) || hex_default;
                  absorb_digit(c);
               end
            end
            SCAN_LEADING_ZERO: begin
               if (c == CH_LO_X) begin
                  hex_mode = 1'b1;
                  scan     = SCAN_DIGITS;
               end else begin
                  hex_mode = hex_default;
                  absorb_digit(c);
               end
            end
            SCAN_DIGITS: absorb_digit(c);
            default: ;
         endcase
         if (last) begin
            values_due.push_back(close_text());
            clear_text();
         end
      endfunction

      function void check_value(logic signed [VALUE_W-1:0] got);
         logic signed [VALUE_W-1:0] want;
         if (values_due.size() == 0) begin
            $display("%0t: unexpected value, expected none, actual %0d", $time, got);
            failures++;
            return;
         end
         want = values_due.pop_front();
         values_checked++;
         if (got !== want) begin
            $display("%0t: value mismatch, expected %0d, actual %0d", $time, want, got);
            failures++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   citp_req_if req_ch ();
   citp_rsp_if rsp_ch ();

   clamped_integer_text_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   parse_scoreboard tracker = new();

   int unsigned burst_left       = 0;
   int unsigned settings_applied = 0;
   int unsigned idle_cycles      = 0;
   logic        text_hex         = 1'b0;
   bit          hold_request     = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver. The ready pattern is re-chosen every so often: always ready, coin
   // flip, mostly ready, or a periodic stall. On request it holds off for a long
   // stretch that it counts itself, so that the block backs up into its input.
   initial begin
      int unsigned hold_left;
      int unsigned mode;
      int unsigned mode_left;
      int unsigned tick;
      hold_left    = 0;
      mode         = 0;
      mode_left    = 0;
      tick         = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= ($urandom_range(0, 7) != 0);
               default: rsp_ch.ready <= (tick % 5 != 0);
            endcase
         end
      end
   end

   // Every result transaction is checked against the oldest parsed value waiting.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_value(rsp_ch.value);
      end
   end

   // The watchdog counts cycles in which neither channel completes a transaction.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Offers one character and waits for its transaction. The sender works in bursts;
   // when a burst runs out it may first drop valid and idle for a random gap. It always returns on a
   // falling edge with valid still high, so the caller drives the next value there.
   task automatic push_char(input logic [CHAR_W-1:0] c, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 40);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      req_ch.is_last   <= last;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_char(c, last);
      @(negedge clock);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_char(s[i], i == s.len() - 1);
      end
   endtask

   // Stops offering and waits until every parsed value has come back, then lets the
   // pipeline settle so that the registers can be written safely.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (tracker.values_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_register(idx, data);
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [CSR_DATA_W-1:0] mx,
                                 input logic [CSR_DATA_W-1:0] mn,
                                 input logic [CSR_DATA_W-1:0] hx);
      write_csr(CSR_MAX_VALUE, mx);
      write_csr(CSR_MIN_VALUE, mn);
      write_csr(CSR_HEX_DEFAULT, hx);
      write_csr(CSR_UNUSED, $urandom());
      csr_we   <= 1'b0;
      text_hex  = hx[0];
      settings_applied++;
   endtask

   // The fixed settings cover the extremes of both limits; the rest are random. The
   // unused upper bits of the narrow registers are written with random values.
   task automatic apply_setting(input int k);
      logic [CSR_DATA_W-1:0] mx;
      logic [CSR_DATA_W-1:0] mn;
      logic [CSR_DATA_W-1:0] hx;
      mx = '0;
      mn = '0;
      hx = $urandom() & ~32'h1;
      case (k)
         0: ;
         1: begin
            mx = 32'h7FFF_FFFF;
            mn = 32'h8000_0000;
         end
         2: begin
            mn    = 32'h8000_0000;
            hx[0] = 1'b1;
         end
         3: begin
            mx = 32'd1;
            mn = 32'h7FFF_FFFF;
         end
         4: begin
            mx     = $urandom();
            mn     = $urandom() | 32'h8000_0000;
            hx[0]  = 1'($urandom_range(0, 1));
         end
         5: begin
            mx    = $urandom_range(1, 1000);
            mn    = 32'($urandom_range(0, 2000)) - 32'd1000;
            hx[0] = 1'($urandom_range(0, 1));
         end
         6: begin
            mn    = 32'hFFFF_FFFF;
            hx[0] = 1'b1;
         end
         default: begin
            mx = $urandom();
            mn = $urandom();
            hx = $urandom();
         end
      endcase
      mx[31] = 1'($urandom_range(0, 1));
      write_settings(mx, mn, hx);
   endtask

   function automatic logic [CHAR_W-1:0] pick_dec();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [CHAR_W-1:0] pick_hex();
      case ($urandom_range(0, 3))
         0:       return CH_ZERO + 8'($urandom_range(0, 9));
         1:       return CH_UP_A + 8'($urandom_range(0, 25));
         2:       return CH_LO_A + 8'($urandom_range(0, 25));
         default: return 8'($urandom_range(CH_ZERO, CH_LO_Z));
      endcase
   endfunction

   // Most texts are well formed numbers with random content, so that long digit runs
   // reach wrap and saturation. The rest are broken prefixes and plain noise.
   task automatic push_random_text();
      logic [CHAR_W-1:0] txt[$];
      int unsigned       r;
      int unsigned       style;
      int unsigned       ndig;
      logic              hexish;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         if ($urandom_range(0, 2) == 0) txt.push_back(CH_MINUS);
         style  = $urandom_range(0, 3);
         ndig   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 6);
         hexish = (style == 1) || (style == 2) || text_hex;
         case (style)
            1: begin
               txt.push_back(CH_ZERO);
               txt.push_back(CH_LO_X);
            end
            2: txt.push_back($urandom_range(0, 1) ? CH_UP_A : CH_LO_A);
            3: txt.push_back(CH_ZERO);
            default: ;
         endcase
         repeat (ndig) txt.push_back(hexish ? pick_hex() : pick_dec());
         if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
         end
      end else if (r < 90) begin
         case ($urandom_range(0, 5))
            0: txt.push_back(CH_MINUS);
            1: begin
               txt.push_back(CH_ZERO);
               txt.push_back(CH_LO_X);
            end
            2: begin
               txt.push_back(CH_MINUS);
               txt.push_back(CH_ZERO);
            end
            3: begin
               txt.push_back(CH_MINUS);
               txt.push_back(CH_MINUS);
               txt.push_back(pick_dec());
            end
            4: begin
               txt.push_back(CH_ZERO);
               txt.push_back(CH_LO_X);
               txt.push_back(8'($urandom_range(0, 255)));
               txt.push_back(pick_hex());
            end
            default: begin
               txt.push_back(CH_ZERO);
               txt.push_back(CH_ZERO);
               txt.push_back(CH_LO_X);
               txt.push_back(pick_hex());
            end
         endcase
      end else begin
         repeat ($urandom_range(1, 5)) txt.push_back(8'($urandom_range(0, 255)));
      end
      foreach (txt[i]) push_char(txt[i], i == txt.size() - 1);
   endtask

   initial begin
      int unsigned phase_start;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      req_ch.is_last   = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_MAX_VALUE;
      csr_wdata        = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed texts under the reset settings: unlimited magnitude, a zero floor
      // that turns every negative text into zero, decimal by default. They cover the
      // hex prefix, a leading letter, a lone zero, a bare sign, a digit run ended by a
      // letter, and the two extreme character codes.
      push_text("7");
      push_text("-12");
      push_text("0x1F");
      push_text("a9");
      push_text("0");
      push_text("-");
      push_text("5z");
      push_char(8'hFF, 1'b1);
      push_char(8'h00, 1'b1);

      // Hex by default with a small limit: the second digit saturates, and the
      // negative floor then bounds the negative text.
      drain();
      write_settings(32'd100, 32'hFFFF_FFCE, 32'd1);
      push_text("999");
      push_text("-999");

      // Random phases, one per register setting. The sender waits for every result
      // before each change. In one phase the receiver holds off for a long stretch
      // while a long burst keeps the sender offering characters.
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         drain();
         apply_setting(k);
         if (k == 4) begin
            hold_request = 1'b1;
            burst_left   = 200;
         end
         phase_start = tracker.chars_seen;
         while (tracker.chars_seen - phase_start < PHASE_CHARS) push_random_text();
      end

      drain();
      if (tracker.values_due.size() != 0) begin
         $display("%0t: %0d expected values never arrived", $time, tracker.values_due.size());
      end
      $display("Sent %0d characters and checked %0d parsed values over %0d register settings,",
               tracker.chars_seen, tracker.values_checked, settings_applied);
      $display("with wrap, saturation, sign clamps and a %0d-cycle receiver hold-off.",
               HOLD_OFF_CYCLES);
      if (tracker.failures == 0 && tracker.values_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/citp_pkg.sv
hw/rtl/citp_req_if.sv
hw/rtl/citp_rsp_if.sv
hw/rtl/clamped_integer_text_parser.sv
tb/testbench.sv
